// ----- src/plw_pkg.sv -----
// ----------------------------------------------------------------------------
// plw_pkg: shared types and constants
// Command record, configuration record, codes and reset values.
// ----------------------------------------------------------------------------
package plw_pkg;

    localparam int DEF_MAX_LANDMARKS    = 64;
    localparam int DEF_MAX_OBSERVATIONS = 16;
    localparam int DEF_SINE_ENTRIES     = 1024;

    localparam logic [1:0] ACT_MARK  = 2'd0;
    localparam logic [1:0] ACT_SEEN  = 2'd1;
    localparam logic [1:0] ACT_SCORE = 2'd2;

    localparam logic [2:0] CFG_RANGE_SQ  = 3'd0;
    localparam logic [2:0] CFG_GAIN_X    = 3'd1;
    localparam logic [2:0] CFG_GAIN_Y    = 3'd2;
    localparam logic [2:0] CFG_LOG_NORM  = 3'd3;
    localparam logic [2:0] CFG_UFL_LIMIT = 3'd4;
    localparam logic [2:0] CFG_EPS_TERM  = 3'd5;

    localparam logic [47:0] RST_RANGE_SQ  = 48'd163840000;
    localparam logic [23:0] RST_GAIN_X    = 24'd364089;
    localparam logic [23:0] RST_GAIN_Y    = 24'd364089;
    localparam logic [23:0] RST_LOG_NORM  = 24'd37356;
    localparam logic [30:0] RST_UFL_LIMIT = 31'd48824320;
    localparam logic [30:0] RST_EPS_TERM  = 31'd754350;

    typedef struct packed {
        logic [1:0]         kind;
        logic [5:0]         slot;
        logic [15:0]        tag;
        logic signed [23:0] pos_x;
        logic signed [23:0] pos_y;
        logic [15:0]        heading;
        logic [6:0]         marks_used;
        logic [4:0]         obs_used;
    } t_cmd;

    typedef struct packed {
        logic [47:0]        range_sq;
        logic [23:0]        gain_x;
        logic [23:0]        gain_y;
        logic signed [23:0] log_norm;
        logic [30:0]        ufl_limit;
        logic [30:0]        eps_term;
    } t_cfg;

endpackage

// ----- src/plw_front.sv -----
// ----------------------------------------------------------------------------
// plw_front: input stage
// Accepts items, drops those that have no effect and queues the rest.
// ----------------------------------------------------------------------------
module plw_front import plw_pkg::*; #(
    parameter int MAX_LANDMARKS    = DEF_MAX_LANDMARKS,
    parameter int MAX_OBSERVATIONS = DEF_MAX_OBSERVATIONS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    output logic               o_full,
    input  t_cmd               i_cmd,
    output logic               o_head_valid,
    output t_cmd               o_head,
    input  logic               i_head_take
);

    t_cmd       r_q [2];
    logic       r_rd;
    logic       r_wr;
    logic [1:0] r_cnt;
    logic       keep;
    logic       put;
    logic       take;

    always_comb begin
        case (i_cmd.kind)
            ACT_MARK:  keep = int'(i_cmd.slot) < MAX_LANDMARKS;
            ACT_SEEN:  keep = int'(i_cmd.slot) < MAX_OBSERVATIONS;
            ACT_SCORE: keep = 1'b1;
            default:   keep = 1'b0;
        endcase
    end

    assign o_full       = (r_cnt == 2'd2);
    assign o_head_valid = (r_cnt != 2'd0);
    assign o_head       = r_q[r_rd];
    assign put          = i_push && !o_full && keep;
    assign take         = i_head_take && o_head_valid;

    always_ff @(posedge i_clk) begin
        if (put) begin
            r_q[r_wr] <= i_cmd;
        end
        if (!i_rst_n) begin
            r_rd  <= 1'b0;
            r_wr  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (put) begin
                r_wr <= !r_wr;
            end
            if (take) begin
                r_rd <= !r_rd;
            end
            r_cnt <= r_cnt + {1'b0, put} - {1'b0, take};
        end
    end

endmodule

// ----- src/plw_back.sv -----
// ----------------------------------------------------------------------------
// plw_back: execution stage
// Holds the tables and scores one particle at a time with a shared
// distance pipeline, then presents the result in an output register.
// ----------------------------------------------------------------------------
module plw_back import plw_pkg::*; #(
    parameter int MAX_LANDMARKS    = DEF_MAX_LANDMARKS,
    parameter int MAX_OBSERVATIONS = DEF_MAX_OBSERVATIONS,
    parameter int SINE_ENTRIES     = DEF_SINE_ENTRIES
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_cfg         i_cfg,
    input  logic         i_head_valid,
    input  t_cmd         i_head,
    output logic         o_head_take,
    output logic         o_res_valid,
    output logic [15:0]  o_res_tag,
    output logic [39:0]  o_res_sum,
    input  logic         i_res_pop
);

    localparam int LW  = (MAX_LANDMARKS > 1) ? $clog2(MAX_LANDMARKS) : 1;
    localparam int LCW = $clog2(MAX_LANDMARKS + 1);
    localparam int OW  = (MAX_OBSERVATIONS > 1) ? $clog2(MAX_OBSERVATIONS) : 1;
    localparam int OCW = $clog2(MAX_OBSERVATIONS + 1);
    localparam int RA  = $clog2(SINE_ENTRIES + 1);
    localparam int PW  = $clog2(4 * SINE_ENTRIES);
    localparam logic [63:0] PIH_Q30 = 64'd1686629713;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_SIN0    = 4'd1;
    localparam logic [3:0] S_SIN1    = 4'd2;
    localparam logic [3:0] S_SIN2    = 4'd3;
    localparam logic [3:0] S_SCAN    = 4'd4;
    localparam logic [3:0] S_OBS_RD  = 4'd5;
    localparam logic [3:0] S_ROT_MUL = 4'd6;
    localparam logic [3:0] S_ROT_ADD = 4'd7;
    localparam logic [3:0] S_W_MUL   = 4'd8;
    localparam logic [3:0] S_W_ADD   = 4'd9;
    localparam logic [3:0] S_W_TERM  = 4'd10;
    localparam logic [3:0] S_DONE    = 4'd11;

    typedef logic [15:0] t_rom [0:SINE_ENTRIES];

    function automatic t_rom build_rom();
        t_rom        rom;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic signed [63:0] sum;
        logic signed [63:0] r;
        for (int k = 0; k <= SINE_ENTRIES; k++) begin
            x    = (PIH_Q30 * 64'(k)) / SINE_ENTRIES;
            x2   = (x * x) >> 30;
            term = x;
            sum  = $signed(x);
            term = ((term * x2) >> 30) / 6;
            sum  = sum - $signed(term);
            term = ((term * x2) >> 30) / 20;
            sum  = sum + $signed(term);
            term = ((term * x2) >> 30) / 42;
            sum  = sum - $signed(term);
            term = ((term * x2) >> 30) / 72;
            sum  = sum + $signed(term);
            term = ((term * x2) >> 30) / 110;
            sum  = sum - $signed(term);
            if (sum < 0) begin
                sum = 0;
            end
            r = (sum + 64'sd16384) >>> 15;
            if (r > 64'sd32768) begin
                r = 64'sd32768;
            end
            rom[k] = r[15:0];
        end
        return rom;
    endfunction

    localparam t_rom SINE_ROM = build_rom();

    logic signed [23:0] mark_x [MAX_LANDMARKS];
    logic signed [23:0] mark_y [MAX_LANDMARKS];
    logic signed [23:0] seen_x [MAX_OBSERVATIONS];
    logic signed [23:0] seen_y [MAX_OBSERVATIONS];

    logic [3:0]          r_state;
    logic [15:0]         r_tag;
    logic signed [23:0]  r_px;
    logic signed [23:0]  r_py;
    logic [15:0]         r_head;
    logic [LCW-1:0]      r_nl;
    logic [OCW-1:0]      r_no;
    logic [OCW-1:0]      r_j;
    logic [15:0]         r_rom_q;
    logic                r_neg;
    logic signed [16:0]  r_sin;
    logic signed [16:0]  r_cos;
    logic signed [23:0]  r_ox;
    logic signed [23:0]  r_oy;
    logic signed [40:0]  r_cox;
    logic signed [40:0]  r_soy;
    logic signed [40:0]  r_sox;
    logic signed [40:0]  r_coy;
    logic signed [27:0]  r_cx;
    logic signed [27:0]  r_cy;
    logic                r_search;
    logic [LCW-1:0]      r_iss;
    logic signed [23:0]  r_rdx;
    logic signed [23:0]  r_rdy;
    logic                r_v1;
    logic                r_v2;
    logic                r_v3;
    logic [LW-1:0]       r_idx1;
    logic [LW-1:0]       r_idx2;
    logic [LW-1:0]       r_idx3;
    logic [28:0]         r_ax;
    logic [28:0]         r_ay;
    logic [57:0]         r_sqx;
    logic [57:0]         r_sqy;
    logic [MAX_LANDMARKS-1:0] r_inr;
    logic                r_found;
    logic [58:0]         r_bestd;
    logic [57:0]         r_bsqx;
    logic [57:0]         r_bsqy;
    logic [55:0]         r_mxh;
    logic [49:0]         r_mxl;
    logic [55:0]         r_myh;
    logic [49:0]         r_myl;
    logic [63:0]         r_wx;
    logic [63:0]         r_wy;
    logic [39:0]         r_sum;
    logic                r_res_valid;
    logic [15:0]         r_res_tag;
    logic [39:0]         r_res_sum;

    logic                take;
    logic [16+PW-1:0]    ph_prod;
    logic [PW-1:0]       ph;
    logic [PW:0]         ph_cos_ext;
    logic [PW-1:0]       ph_cos;
    logic [RA-1:0]       sin_idx;
    logic                sin_neg;
    logic [RA-1:0]       cos_idx;
    logic                cos_neg;
    logic [RA-1:0]       rom_addr;
    logic                issue;
    logic                scan_done;
    logic signed [28:0]  dx;
    logic signed [28:0]  dy;
    logic [58:0]         dsum;
    logic signed [41:0]  rot_x;
    logic signed [41:0]  rot_y;
    logic [81:0]         wsum_x;
    logic [81:0]         wsum_y;
    logic [63:0]         term;
    logic [63:0]         term_sel;
    logic                res_free;
    logic                res_load;

    function automatic logic [RA:0] fold(input logic [PW-1:0] p);
        logic [PW-1:0] r;
        logic [1:0]    q;
        logic [RA-1:0] idx;
        if (int'(p) < SINE_ENTRIES) begin
            q = 2'd0;
            r = p;
        end else if (int'(p) < 2 * SINE_ENTRIES) begin
            q = 2'd1;
            r = p - PW'(SINE_ENTRIES);
        end else if (int'(p) < 3 * SINE_ENTRIES) begin
            q = 2'd2;
            r = p - PW'(2 * SINE_ENTRIES);
        end else begin
            q = 2'd3;
            r = p - PW'(3 * SINE_ENTRIES);
        end
        idx = q[0] ? RA'(SINE_ENTRIES - int'(r)) : RA'(r);
        return {q[1], idx};
    endfunction

    assign ph_prod    = (16 + PW)'(r_head) * (16 + PW)'(4 * SINE_ENTRIES);
    assign ph         = ph_prod[16+PW-1:16];
    assign ph_cos_ext = (PW + 1)'(ph) + (PW + 1)'(SINE_ENTRIES);
    assign ph_cos     = (int'(ph_cos_ext) >= 4 * SINE_ENTRIES)
                      ? PW'(ph_cos_ext - (PW + 1)'(4 * SINE_ENTRIES)) : PW'(ph_cos_ext);
    assign {sin_neg, sin_idx} = fold(ph);
    assign {cos_neg, cos_idx} = fold(ph_cos);
    assign rom_addr = (r_state == S_SIN0) ? sin_idx : cos_idx;

    assign take        = (r_state == S_IDLE) && i_head_valid;
    assign o_head_take = take;

    assign issue     = (r_state == S_SCAN) && (r_iss < r_nl);
    assign scan_done = (r_state == S_SCAN) && !issue && !r_v1 && !r_v2 && !r_v3;

    assign dx   = 29'(r_cx) - 29'(r_rdx);
    assign dy   = 29'(r_cy) - 29'(r_rdy);
    assign dsum = 59'(r_sqx) + 59'(r_sqy);

    assign rot_x = 42'(r_cox) - 42'(r_soy);
    assign rot_y = 42'(r_sox) + 42'(r_coy);

    assign wsum_x = {r_mxh, 26'd0} + 82'(r_mxl);
    assign wsum_y = {r_myh, 26'd0} + 82'(r_myl);

    assign term     = r_wx + r_wy - 64'(i_cfg.log_norm);
    assign term_sel = ($signed(term) > $signed({33'd0, i_cfg.ufl_limit}))
                    ? 64'(i_cfg.eps_term) : term;

    assign res_free = !r_res_valid || i_res_pop;
    assign res_load = (r_state == S_DONE) && res_free;

    always_ff @(posedge i_clk) begin
        if (take && i_head.kind == ACT_MARK) begin
            mark_x[LW'(i_head.slot)] <= i_head.pos_x;
            mark_y[LW'(i_head.slot)] <= i_head.pos_y;
        end
        if (take && i_head.kind == ACT_SEEN) begin
            seen_x[OW'(i_head.slot)] <= i_head.pos_x;
            seen_y[OW'(i_head.slot)] <= i_head.pos_y;
        end
        r_rdx   <= mark_x[r_iss[LW-1:0]];
        r_rdy   <= mark_y[r_iss[LW-1:0]];
        r_ox    <= seen_x[r_j[OW-1:0]];
        r_oy    <= seen_y[r_j[OW-1:0]];
        r_rom_q <= SINE_ROM[rom_addr];
    end

    always_ff @(posedge i_clk) begin
        r_idx1 <= r_iss[LW-1:0];
        r_idx2 <= r_idx1;
        r_idx3 <= r_idx2;
        r_ax   <= dx[28] ? 29'(-dx) : 29'(dx);
        r_ay   <= dy[28] ? 29'(-dy) : 29'(dy);
        r_sqx  <= 58'(r_ax) * 58'(r_ax);
        r_sqy  <= 58'(r_ay) * 58'(r_ay);
        r_cox  <= 41'(r_cos) * 41'(r_ox);
        r_soy  <= 41'(r_sin) * 41'(r_oy);
        r_sox  <= 41'(r_sin) * 41'(r_ox);
        r_coy  <= 41'(r_cos) * 41'(r_oy);
        r_mxh  <= 56'(r_bsqx[57:26]) * 56'(i_cfg.gain_x);
        r_mxl  <= 50'(r_bsqx[25:0]) * 50'(i_cfg.gain_x);
        r_myh  <= 56'(r_bsqy[57:26]) * 56'(i_cfg.gain_y);
        r_myl  <= 50'(r_bsqy[25:0]) * 50'(i_cfg.gain_y);
        r_wx   <= wsum_x[79:16];
        r_wy   <= wsum_y[79:16];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            r_v1 <= issue;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            if (res_load) begin
                r_res_valid <= 1'b1;
            end else if (i_res_pop) begin
                r_res_valid <= 1'b0;
            end
            if (issue) begin
                r_iss <= r_iss + 1'b1;
            end
            if (r_v3) begin
                if (!r_search) begin
                    r_inr[r_idx3] <= (dsum <= 59'(i_cfg.range_sq));
                end else if (r_inr[r_idx3] && (!r_found || dsum < r_bestd)) begin
                    r_found <= 1'b1;
                    r_bestd <= dsum;
                    r_bsqx  <= r_sqx;
                    r_bsqy  <= r_sqy;
                end
            end
            case (r_state)
                S_IDLE: begin
                    if (take && i_head.kind == ACT_SCORE) begin
                        r_tag  <= i_head.tag;
                        r_px   <= i_head.pos_x;
                        r_py   <= i_head.pos_y;
                        r_head <= i_head.heading;
                        r_nl   <= (int'(i_head.marks_used) > MAX_LANDMARKS)
                                ? LCW'(MAX_LANDMARKS) : LCW'(i_head.marks_used);
                        r_no   <= (int'(i_head.obs_used) > MAX_OBSERVATIONS)
                                ? OCW'(MAX_OBSERVATIONS) : OCW'(i_head.obs_used);
                        r_state <= S_SIN0;
                    end
                end
                S_SIN0: begin
                    r_neg   <= sin_neg;
                    r_state <= S_SIN1;
                end
                S_SIN1: begin
                    r_sin   <= r_neg ? -$signed({1'b0, r_rom_q}) : $signed({1'b0, r_rom_q});
                    r_neg   <= cos_neg;
                    r_state <= S_SIN2;
                end
                S_SIN2: begin
                    r_cos    <= r_neg ? -$signed({1'b0, r_rom_q}) : $signed({1'b0, r_rom_q});
                    r_cx     <= 28'(r_px);
                    r_cy     <= 28'(r_py);
                    r_search <= 1'b0;
                    r_iss    <= '0;
                    r_sum    <= '0;
                    r_state  <= S_SCAN;
                end
                S_SCAN: begin
                    if (scan_done) begin
                        if (!r_search) begin
                            r_j     <= '0;
                            r_state <= S_OBS_RD;
                        end else if (!r_found) begin
                            r_sum   <= r_sum + 40'(i_cfg.eps_term);
                            r_j     <= r_j + 1'b1;
                            r_state <= S_OBS_RD;
                        end else begin
                            r_state <= S_W_MUL;
                        end
                    end
                end
                S_OBS_RD: begin
                    r_state <= (r_j == r_no) ? S_DONE : S_ROT_MUL;
                end
                S_ROT_MUL: begin
                    r_state <= S_ROT_ADD;
                end
                S_ROT_ADD: begin
                    r_cx     <= 28'($signed(rot_x[41:15])) + 28'(r_px);
                    r_cy     <= 28'($signed(rot_y[41:15])) + 28'(r_py);
                    r_search <= 1'b1;
                    r_found  <= 1'b0;
                    r_iss    <= '0;
                    r_state  <= S_SCAN;
                end
                S_W_MUL: begin
                    r_state <= S_W_ADD;
                end
                S_W_ADD: begin
                    r_state <= S_W_TERM;
                end
                S_W_TERM: begin
                    r_sum   <= r_sum + term_sel[39:0];
                    r_j     <= r_j + 1'b1;
                    r_state <= S_OBS_RD;
                end
                S_DONE: begin
                    if (res_free) begin
                        r_res_tag   <= r_tag;
                        r_res_sum   <= r_sum;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_res_tag   = r_res_tag;
    assign o_res_sum   = r_res_sum;

endmodule

// ----- src/particle_landmark_weight_unit.sv -----
// ----------------------------------------------------------------------------
// A particle item passes the sine lookups, a range scan of its L landmarks
// and, for each of its N observations, a rotation and a search scan.
// Throughput is set by the distance pipeline, one landmark per cycle.
// Reset restores the register defaults and empties both queues;
// the landmark and observation tables are undefined until loaded.
// ----------------------------------------------------------------------------
module particle_landmark_weight_unit import plw_pkg::*; #(
    parameter int MAX_LANDMARKS    = DEF_MAX_LANDMARKS,
    parameter int MAX_OBSERVATIONS = DEF_MAX_OBSERVATIONS,
    parameter int SINE_ENTRIES     = DEF_SINE_ENTRIES
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  logic [1:0]         i_action,
    input  logic [5:0]         i_slot,
    input  logic [15:0]        i_tag,
    input  logic signed [23:0] i_pos_x,
    input  logic signed [23:0] i_pos_y,
    input  logic [15:0]        i_heading,
    input  logic [6:0]         i_landmarks_used,
    input  logic [4:0]         i_observations_used,
    output logic               empty,
    input  logic               pop,
    output logic [15:0]        o_particle_tag,
    output logic signed [39:0] o_neg_log_weight,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [47:0]        i_cfg_data
);

    t_cfg        r_cfg;
    t_cmd        cmd;
    t_cmd        head;
    logic        head_valid;
    logic        head_take;
    logic        res_valid;
    logic [39:0] res_sum;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.range_sq  <= RST_RANGE_SQ;
            r_cfg.gain_x    <= RST_GAIN_X;
            r_cfg.gain_y    <= RST_GAIN_Y;
            r_cfg.log_norm  <= RST_LOG_NORM;
            r_cfg.ufl_limit <= RST_UFL_LIMIT;
            r_cfg.eps_term  <= RST_EPS_TERM;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_RANGE_SQ:  r_cfg.range_sq  <= i_cfg_data;
                CFG_GAIN_X:    r_cfg.gain_x    <= i_cfg_data[23:0];
                CFG_GAIN_Y:    r_cfg.gain_y    <= i_cfg_data[23:0];
                CFG_LOG_NORM:  r_cfg.log_norm  <= i_cfg_data[23:0];
                CFG_UFL_LIMIT: r_cfg.ufl_limit <= i_cfg_data[30:0];
                CFG_EPS_TERM:  r_cfg.eps_term  <= i_cfg_data[30:0];
                default: begin
                end
            endcase
        end
    end

    assign cmd.kind       = i_action;
    assign cmd.slot       = i_slot;
    assign cmd.tag        = i_tag;
    assign cmd.pos_x      = i_pos_x;
    assign cmd.pos_y      = i_pos_y;
    assign cmd.heading    = i_heading;
    assign cmd.marks_used = i_landmarks_used;
    assign cmd.obs_used   = i_observations_used;

    plw_front #(
        .MAX_LANDMARKS    (MAX_LANDMARKS),
        .MAX_OBSERVATIONS (MAX_OBSERVATIONS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_full       (full),
        .i_cmd        (cmd),
        .o_head_valid (head_valid),
        .o_head       (head),
        .i_head_take  (head_take)
    );

    plw_back #(
        .MAX_LANDMARKS    (MAX_LANDMARKS),
        .MAX_OBSERVATIONS (MAX_OBSERVATIONS),
        .SINE_ENTRIES     (SINE_ENTRIES)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_head_valid (head_valid),
        .i_head       (head),
        .o_head_take  (head_take),
        .o_res_valid  (res_valid),
        .o_res_tag    (o_particle_tag),
        .o_res_sum    (res_sum),
        .i_res_pop    (pop && res_valid)
    );

    assign empty            = !res_valid;
    assign o_neg_log_weight = $signed(res_sum);

endmodule

// ----- dv/plw_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plw_checker: result predictor and scoreboard for the landmark weight unit
// Watches the item, result and register channels. It keeps its own copy of
// the tables and registers, scores each accepted particle item and compares
// every popped result, in order, with the oldest predicted score.
// ----------------------------------------------------------------------------
module plw_checker import plw_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  logic               i_full,
    input  logic [1:0]         i_action,
    input  logic [5:0]         i_slot,
    input  logic [15:0]        i_tag,
    input  logic signed [23:0] i_pos_x,
    input  logic signed [23:0] i_pos_y,
    input  logic [15:0]        i_heading,
    input  logic [6:0]         i_landmarks_used,
    input  logic [4:0]         i_observations_used,
    input  logic               i_empty,
    input  logic               i_pop,
    input  logic [15:0]        i_particle_tag,
    input  logic signed [39:0] i_neg_log_weight,
    input  logic               i_cfg_valid,
    input  logic               i_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [47:0]        i_cfg_data,
    output int                 o_fail_count,
    output int                 o_waiting,
    output int                 o_scored
);

    localparam int NMARK = DEF_MAX_LANDMARKS;
    localparam int NOBS  = DEF_MAX_OBSERVATIONS;
    localparam int NSIN  = DEF_SINE_ENTRIES;

    typedef struct {
        logic [15:0]        tag;
        logic signed [39:0] weight;
    } t_score;

    t_score             score_queue[$];
    t_cfg               regs;
    logic signed [23:0] map_x[NMARK];
    logic signed [23:0] map_y[NMARK];
    logic signed [23:0] obs_x[NOBS];
    logic signed [23:0] obs_y[NOBS];
    longint             sine_rom[NSIN + 1];

    function automatic longint quarter_wave(int k);
        longint unsigned x, x2, term;
        longint          acc, r;
        x    = (64'd1686629713 * longint'(k)) / NSIN;
        x2   = (x * x) >> 30;
        term = x;
        acc  = longint'(x);
        for (int n = 1; n <= 5; n++) begin
            term = (term * x2) >> 30;
            term = term / ((2 * n) * (2 * n + 1));
            if (n % 2 == 1) begin
                acc -= longint'(term);
            end else begin
                acc += longint'(term);
            end
        end
        if (acc < 0) acc = 0;
        r = (acc + 16384) >>> 15;
        return (r > 32768) ? 32768 : r;
    endfunction

    function automatic longint sine_of(int p);
        int     quad, rem;
        longint v;
        quad = p / NSIN;
        rem  = p % NSIN;
        v    = sine_rom[(quad % 2 == 1) ? NSIN - rem : rem];
        return (quad & 2) ? -v : v;
    endfunction

    function automatic longint unsigned dist_sq(longint d);
        longint unsigned a;
        a = (d < 0) ? longint'(-d) : longint'(d);
        return a * a;
    endfunction

    function automatic longint unsigned gain_scale(longint unsigned q, longint unsigned g);
        return (q >> 16) * g + (((q & 64'hFFFF) * g) >> 16);
    endfunction

    function automatic longint particle_score(t_cmd c);
        int              nl, no, phase;
        longint          px, py, s, co, mx, my, t, total;
        longint unsigned d, bestd, a;
        int              best;
        bit              found;
        bit              near[NMARK];
        nl    = (c.marks_used > NMARK) ? NMARK : int'(c.marks_used);
        no    = (c.obs_used > NOBS) ? NOBS : int'(c.obs_used);
        px    = c.pos_x;
        py    = c.pos_y;
        total = 0;
        for (int i = 0; i < nl; i++) begin
            near[i] = dist_sq(px - map_x[i]) + dist_sq(py - map_y[i]) <= regs.range_sq;
        end
        phase = (int'(c.heading) * 4 * NSIN) >> 16;
        s     = sine_of(phase);
        co    = sine_of((phase + NSIN) % (4 * NSIN));
        for (int j = 0; j < no; j++) begin
            mx    = ((co * obs_x[j] - s * obs_y[j]) >>> 15) + px;
            my    = ((s * obs_x[j] + co * obs_y[j]) >>> 15) + py;
            found = 0;
            bestd = 0;
            best  = 0;
            for (int i = 0; i < nl; i++) begin
                if (near[i]) begin
                    d = dist_sq(mx - map_x[i]) + dist_sq(my - map_y[i]);
                    if (!found || d < bestd) begin
                        found = 1;
                        bestd = d;
                        best  = i;
                    end
                end
            end
            if (!found) begin
                t = longint'(regs.eps_term);
            end else begin
                a = gain_scale(dist_sq(mx - map_x[best]), regs.gain_x)
                  + gain_scale(dist_sq(my - map_y[best]), regs.gain_y);
                t = longint'(a) - longint'(regs.log_norm);
                if (t > longint'(regs.ufl_limit)) t = longint'(regs.eps_term);
            end
            total += t;
        end
        return total;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        o_fail_count++;
    endtask

    initial begin
        o_fail_count = 0;
        o_scored     = 0;
        o_waiting    = 0;
        for (int k = 0; k <= NSIN; k++) sine_rom[k] = quarter_wave(k);
    end

    always @(posedge i_clk) begin
        t_cmd   cmd;
        t_score item;
        if (!i_rst_n) begin
            regs.range_sq  = RST_RANGE_SQ;
            regs.gain_x    = RST_GAIN_X;
            regs.gain_y    = RST_GAIN_Y;
            regs.log_norm  = RST_LOG_NORM;
            regs.ufl_limit = RST_UFL_LIMIT;
            regs.eps_term  = RST_EPS_TERM;
            score_queue.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_RANGE_SQ:  regs.range_sq  = i_cfg_data;
                    CFG_GAIN_X:    regs.gain_x    = i_cfg_data[23:0];
                    CFG_GAIN_Y:    regs.gain_y    = i_cfg_data[23:0];
                    CFG_LOG_NORM:  regs.log_norm  = i_cfg_data[23:0];
                    CFG_UFL_LIMIT: regs.ufl_limit = i_cfg_data[30:0];
                    CFG_EPS_TERM:  regs.eps_term  = i_cfg_data[30:0];
                    default: ;
                endcase
            end
            if (i_pop && !i_empty) begin
                if (score_queue.size() == 0) begin
                    report_mismatch("unexpected result, tag", i_particle_tag, -1);
                end else begin
                    item = score_queue.pop_front();
                    o_scored++;
                    if (i_particle_tag !== item.tag)
                        report_mismatch("particle_tag", i_particle_tag, item.tag);
                    if (i_neg_log_weight !== item.weight)
                        report_mismatch("neg_log_weight", i_neg_log_weight, item.weight);
                end
            end
            if (i_push && !i_full) begin
                cmd = '{i_action, i_slot, i_tag, i_pos_x, i_pos_y, i_heading,
                        i_landmarks_used, i_observations_used};
                case (cmd.kind)
                    ACT_MARK: begin
                        map_x[cmd.slot] = cmd.pos_x;
                        map_y[cmd.slot] = cmd.pos_y;
                    end
                    ACT_SEEN: begin
                        if (cmd.slot < NOBS) begin
                            obs_x[cmd.slot] = cmd.pos_x;
                            obs_y[cmd.slot] = cmd.pos_y;
                        end
                    end
                    ACT_SCORE: begin
                        item.tag    = cmd.tag;
                        item.weight = particle_score(cmd);
                        score_queue.insert(score_queue.size(), item);
                    end
                    default: ;
                endcase
            end
        end
        o_waiting = score_queue.size();
    end

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: stimulus and verdict for the particle landmark weight unit
// Loads landmark and observation tables and scores particles near them under
// four register settings and three pacing regimes, including a long result
// stall that fills the block. Checking is done by plw_checker.
// ----------------------------------------------------------------------------
module tb;
    import plw_pkg::*;

    localparam int STALL_LIMIT = 50000;
    localparam int DRAIN_WAIT  = 1400;
    localparam int HOLD_CYCLES = 3000;

    logic               i_clk = 0;
    logic               i_rst_n = 0;
    logic               push = 0;
    logic               full;
    logic [1:0]         i_action = ACT_MARK;
    logic [5:0]         i_slot = 0;
    logic [15:0]        i_tag = 0;
    logic signed [23:0] i_pos_x = 0;
    logic signed [23:0] i_pos_y = 0;
    logic [15:0]        i_heading = 0;
    logic [6:0]         i_landmarks_used = 0;
    logic [4:0]         i_observations_used = 0;
    logic               empty;
    logic               pop = 0;
    logic [15:0]        o_particle_tag;
    logic signed [39:0] o_neg_log_weight;
    logic               i_cfg_valid = 0;
    logic               o_cfg_ready;
    logic [2:0]         i_cfg_index = CFG_RANGE_SQ;
    logic [47:0]        i_cfg_data = 0;

    int fail_count, waiting, scored;
    int tx_idle = 0, rx_idle = 0, sent = 0, quiet = 0, hold_cnt = 0;
    bit hold_go = 0, hold_done = 0;
    bit mark_set[64];
    bit obs_set[16];
    logic signed [23:0] seq_x[$], seq_y[$];

    always #2 i_clk = ~i_clk;

    particle_landmark_weight_unit dut (.*);

    plw_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .i_full(full),
        .i_action(i_action), .i_slot(i_slot), .i_tag(i_tag), .i_pos_x(i_pos_x),
        .i_pos_y(i_pos_y), .i_heading(i_heading), .i_landmarks_used(i_landmarks_used),
        .i_observations_used(i_observations_used), .i_empty(empty), .i_pop(pop),
        .i_particle_tag(o_particle_tag), .i_neg_log_weight(o_neg_log_weight),
        .i_cfg_valid(i_cfg_valid), .i_cfg_ready(o_cfg_ready), .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data), .o_fail_count(fail_count), .o_waiting(waiting),
        .o_scored(scored)
    );

    // The receiver process owns the long hold-off that fills the block.
    always @(negedge i_clk) begin
        if (hold_go && !hold_done) begin
            pop <= 0;
            hold_cnt++;
            if (hold_cnt >= HOLD_CYCLES) hold_done = 1;
        end else begin
            pop <= ($urandom_range(99) >= rx_idle);
        end
    end

    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty) || (i_cfg_valid && o_cfg_ready)) begin
            quiet <= 0;
        end else begin
            quiet <= quiet + 1;
        end
        if (quiet >= STALL_LIMIT) begin
            $display("Watchdog expired after %0d quiet cycles", quiet);
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic int loaded_prefix(bit marks);
        int n;
        n = 0;
        if (marks) begin
            while (n < 64 && mark_set[n]) n++;
        end else begin
            while (n < 16 && obs_set[n]) n++;
        end
        return n;
    endfunction

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic offer(logic [1:0] kind, logic [5:0] slot, logic [15:0] tag,
                         logic signed [23:0] x, logic signed [23:0] y,
                         logic [15:0] hd, logic [6:0] nl, logic [4:0] no);
        while ($urandom_range(99) < tx_idle) begin
            push <= 0;
            @(negedge i_clk);
        end
        push                <= 1;
        i_action            <= kind;
        i_slot              <= slot;
        i_tag               <= tag;
        i_pos_x             <= x;
        i_pos_y             <= y;
        i_heading           <= hd;
        i_landmarks_used    <= nl;
        i_observations_used <= no;
        forever begin
            @(posedge i_clk);
            if (!full) break;
        end
        @(negedge i_clk);
        sent++;
        if (kind == ACT_MARK) mark_set[slot] = 1;
        if (kind == ACT_SEEN && slot < 16) obs_set[slot] = 1;
    endtask

    task automatic settle();
        push <= 0;
        while (waiting != 0) @(negedge i_clk);
        repeat (DRAIN_WAIT) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [47:0] val);
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        forever begin
            @(posedge i_clk);
            if (o_cfg_ready) break;
        end
        @(negedge i_clk);
        i_cfg_valid <= 0;
    endtask

    task automatic score(logic signed [23:0] x, logic signed [23:0] y);
        int lp, op, nl, no;
        lp = loaded_prefix(1);
        op = loaded_prefix(0);
        nl = (lp == 64 && $urandom_range(3) == 0) ? $urandom_range(127, 64)
                                                  : $urandom_range(lp, 0);
        no = (op == 16 && $urandom_range(3) == 0) ? $urandom_range(31, 16)
                                                  : $urandom_range(op, 0);
        offer(ACT_SCORE, 6'd0, 16'($urandom), x, y, 16'($urandom), 7'(nl), 5'(no));
    endtask

    // One sequence: landmarks around a centre, a few observations, at times an
    // invalid item, then particles scored near the centre.
    task automatic sequence_run();
        int cx, cy, slot, k;
        logic signed [23:0] lx, ly;
        cx = int'($urandom_range(16000000)) - 8000000;
        cy = int'($urandom_range(16000000)) - 8000000;
        seq_x.delete();
        seq_y.delete();
        repeat ($urandom_range(10, 3)) begin
            slot = loaded_prefix(1);
            if (slot == 64 || $urandom_range(4) == 0) slot = $urandom_range(63);
            lx = 24'(cx + int'($urandom_range(32000)) - 16000);
            ly = 24'(cy + int'($urandom_range(32000)) - 16000);
            seq_x.insert(seq_x.size(), lx);
            seq_y.insert(seq_y.size(), ly);
            offer(ACT_MARK, 6'(slot), 16'($urandom), lx, ly, 16'($urandom),
                  7'($urandom), 5'($urandom));
        end
        repeat ($urandom_range(4, 1)) begin
            slot = loaded_prefix(0);
            if (slot == 16 || $urandom_range(4) == 0) slot = $urandom_range(63);
            offer(ACT_SEEN, 6'(slot), 16'($urandom), 24'(int'($urandom_range(16000)) - 8000),
                  24'(int'($urandom_range(16000)) - 8000), 16'($urandom),
                  7'($urandom), 5'($urandom));
        end
        if ($urandom_range(7) == 0)
            offer(2'd3, 6'($urandom), 16'($urandom), 24'($urandom), 24'($urandom),
                  16'($urandom), 7'($urandom), 5'($urandom));
        repeat ($urandom_range(3, 1)) begin
            if ($urandom_range(3) == 0) begin
                k = $urandom_range(seq_x.size() - 1);
                score(seq_x[k], seq_y[k]);
            end else begin
                score(24'(cx + int'($urandom_range(8000)) - 4000),
                      24'(cy + int'($urandom_range(8000)) - 4000));
            end
        end
    endtask

    task automatic random_phase(int count);
        int target;
        target = sent + count;
        while (sent < target) sequence_run();
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);

        // Directed part under reset settings.
        offer(2'd3, 6'h3F, 16'hFFFF, 24'h7FFFFF, 24'h800000, 16'hFFFF, 7'h7F, 5'h1F);
        offer(ACT_SCORE, 0, 16'h0000, 0, 0, 0, 0, 0);
        offer(ACT_SEEN, 0, 0, 24'sd1000, 24'sd0, 0, 0, 0);
        offer(ACT_SEEN, 1, 0, -24'sd700, 24'sd2500, 0, 0, 0);
        offer(ACT_SEEN, 2, 0, 24'h7FFFFF, 24'h7FFFFF, 0, 0, 0);
        offer(ACT_SEEN, 3, 0, 24'h800000, 24'h800000, 0, 0, 0);
        offer(ACT_SEEN, 40, 0, 24'sd5, 24'sd5, 0, 0, 0);
        offer(ACT_SEEN, 63, 0, 24'sd9, 24'sd9, 0, 0, 0);
        offer(ACT_SCORE, 0, 16'hFFFF, 0, 0, 16'h4000, 0, 4);
        offer(ACT_MARK, 0, 16'd7, 24'sd1000, 24'sd0, 0, 0, 0);
        offer(ACT_MARK, 1, 16'd7, 24'sd1000, 24'sd0, 0, 0, 0);
        offer(ACT_MARK, 2, 16'd9, -24'sd800, 24'sd2600, 0, 0, 0);
        offer(ACT_MARK, 3, 16'd3, 24'sd0, 24'sd1000, 0, 0, 0);
        offer(ACT_MARK, 4, 16'd4, 24'h7FFFFF, 24'h800000, 0, 0, 0);
        offer(ACT_SCORE, 6'd1, 16'd1, 0, 0, 16'h0000, 4, 2);
        offer(ACT_SCORE, 0, 16'd2, 0, 0, 16'h4000, 4, 4);
        offer(ACT_SCORE, 0, 16'd3, 0, 0, 16'hFFFF, 5, 4);
        offer(ACT_SCORE, 0, 16'd4, 24'h7FFFFF, 24'h800000, 16'h8000, 5, 4);
        offer(ACT_SCORE, 0, 16'd5, 24'h800000, 24'h7FFFFF, 16'hC000, 5, 2);

        // Pressure: long result stall while items keep coming.
        tx_idle = 26;
        rx_idle = 48;
        hold_go = 1;
        random_phase(120);

        settle();
        write_reg(CFG_RANGE_SQ, 48'hFFFF_FFFF_FFFF);
        write_reg(CFG_GAIN_X, 0);
        write_reg(CFG_GAIN_Y, 24'hFFFFFF);
        write_reg(CFG_LOG_NORM, 48'h80_0000);
        write_reg(CFG_UFL_LIMIT, 31'h7FFF_FFFF);
        write_reg(CFG_EPS_TERM, 31'h7FFF_FFFF);
        tx_idle = 48;
        rx_idle = 26;
        random_phase(140);

        settle();
        write_reg(CFG_RANGE_SQ, 0);
        write_reg(CFG_GAIN_X, 24'hFFFFFF);
        write_reg(CFG_GAIN_Y, 0);
        write_reg(CFG_LOG_NORM, 48'h7F_FFFF);
        write_reg(CFG_UFL_LIMIT, 0);
        write_reg(CFG_EPS_TERM, 0);
        tx_idle = 0;
        rx_idle = 0;
        random_phase(110);

        settle();
        write_reg(CFG_RANGE_SQ, $urandom_range(600000000, 20000000));
        write_reg(CFG_GAIN_X, $urandom_range(2000000, 1000));
        write_reg(CFG_GAIN_Y, $urandom_range(2000000, 1000));
        write_reg(CFG_LOG_NORM, 48'(24'(int'($urandom_range(400000)) - 200000)));
        write_reg(CFG_UFL_LIMIT, $urandom_range(100000000, 1000000));
        write_reg(CFG_EPS_TERM, $urandom_range(2000000));
        random_phase(150);

        settle();
        $display("Run covered %0d items and %0d scored particles over four register",
                 sent, scored);
        $display("settings and three pacing regimes, including a long result stall.");
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
src/plw_pkg.sv
src/plw_front.sv
src/plw_back.sv
src/particle_landmark_weight_unit.sv
dv/plw_checker.sv
dv/tb.sv
